### hw/rtl/footprint_grid_collision_check_assert.svh
// Assertion macros for the footprint collision checker.
`ifndef FOOTPRINT_GRID_COLLISION_CHECK_ASSERT_SVH
`define FOOTPRINT_GRID_COLLISION_CHECK_ASSERT_SVH

// Same-cycle implication, clocked on clk, off during reset.
`define FGCC_ASSERT_IMP(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("footprint collision check: assertion failed");

// Next-cycle implication, clocked on clk, off during reset.
`define FGCC_ASSERT_NXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("footprint collision check: assertion failed");

`endif

### hw/rtl/fgcc_pkg.sv
// Shared constants and types of the footprint collision checker.
package fgcc_pkg;

    localparam int MAP_SIDE        = 256;
    localparam int MAP_CELLS       = MAP_SIDE * MAP_SIDE;
    localparam int MAP_AW          = $clog2(MAP_CELLS);
    localparam int COORD_FRAC_BITS = 10;
    localparam int TRIG_FRAC_BITS  = 14;

    localparam int DIM_W    = 9;
    localparam int EXT_W    = 13;
    localparam int POSE_W   = 24;
    localparam int TRIG_W   = 16;
    localparam int LAT_W    = EXT_W + 2;
    localparam int PROD_W   = LAT_W + TRIG_W;
    localparam int FPROD_W  = PROD_W - TRIG_FRAC_BITS;
    localparam int MAPC_W   = POSE_W + 2;
    localparam int LIM_W    = DIM_W + EXT_W;
    localparam int RECIP_SH = LIM_W + 1;
    localparam int RECIP_W  = RECIP_SH - 4 + 1;
    localparam int QUOT_W   = DIM_W + 1;
    localparam int IDX_W    = 2 * DIM_W + 1;

    localparam int MIN_CELL     = 16;
    localparam int FRAC_ONE     = 1 << COORD_FRAC_BITS;
    localparam int CELL_CM      = 5;
    localparam int CAR_LEN_CM   = 228;
    localparam int CAR_WID_CM   = 120;
    localparam int REAR_AXLE_CM = 45;
    localparam int PAD_CM       = 20;

    localparam logic [EXT_W-1:0] CELL_RST =
        EXT_W'((CELL_CM * FRAC_ONE + 50) / 100);
    localparam logic [EXT_W-1:0] REAR_RST =
        EXT_W'(((REAR_AXLE_CM + PAD_CM) * FRAC_ONE + 50) / 100);
    localparam logic [EXT_W-1:0] FRONT_RST =
        EXT_W'(((CAR_LEN_CM - REAR_AXLE_CM + PAD_CM) * FRAC_ONE + 50) / 100);
    localparam logic [EXT_W-1:0] SIDE_RST =
        EXT_W'(((CAR_WID_CM / 2 + PAD_CM) * FRAC_ONE + 50) / 100);

    localparam logic [2:0] REG_MAP_WIDTH  = 3'd0;
    localparam logic [2:0] REG_MAP_HEIGHT = 3'd1;
    localparam logic [2:0] REG_CELL_SIZE  = 3'd2;
    localparam logic [2:0] REG_REAR       = 3'd3;
    localparam logic [2:0] REG_FRONT      = 3'd4;
    localparam logic [2:0] REG_SIDE       = 3'd5;

    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    // Per-query context seen by the point pipeline
    typedef struct packed {
        logic signed [POSE_W-1:0] px;
        logic signed [POSE_W-1:0] py;
        logic signed [TRIG_W-1:0] c;
        logic signed [TRIG_W-1:0] s;
        logic [EXT_W-1:0]         cs;
        logic [LIM_W-1:0]         lx;
        logic [LIM_W-1:0]         ly;
        logic [RECIP_W-1:0]       recip;
        logic [DIM_W-1:0]         width;
    } fgcc_ctx_t;

    // One lattice point entering the pipeline
    typedef struct packed {
        logic                      valid;
        logic signed [LAT_W-1:0]   sy;
        logic signed [FPROD_W-1:0] fxc;
        logic signed [FPROD_W-1:0] fxs;
    } fgcc_pt_t;

endpackage

### hw/rtl/fgcc_ram.sv
// Generic word-addressable RAM with one write port and one registered read port.
module fgcc_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 65536
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

### hw/rtl/fgcc_recip.sv
// Bit-serial reciprocal of the cell size, one quotient bit per cycle.
module fgcc_recip (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [fgcc_pkg::EXT_W-1:0]  divisor,
    output logic                        done,
    output logic [fgcc_pkg::RECIP_W-1:0] quot
);
    import fgcc_pkg::*;

    localparam int CNT_W = $clog2(RECIP_SH + 1);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [EXT_W-1:0] rem_reg, rem_next;
    logic [RECIP_W-1:0] q_reg, q_next;
    logic [EXT_W:0]   shifted;
    logic             dbit;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        q_next    = q_reg;
        dbit      = (cnt_reg == CNT_W'(RECIP_SH));
        shifted   = {rem_reg, dbit};
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(RECIP_SH);
            rem_next  = '0;
            q_next    = '0;
        end
        else if (busy_reg)
        begin
            // restoring step: subtract when the partial remainder allows it
            if (shifted >= {1'b0, divisor})
            begin
                rem_next = EXT_W'(shifted - {1'b0, divisor});
                q_next   = {q_reg[RECIP_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = shifted[EXT_W-1:0];
                q_next   = {q_reg[RECIP_W-2:0], 1'b0};
            end
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                cnt_next = cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        q_reg   <= q_next;
    end

    assign done = done_reg;
    assign quot = q_reg;

endmodule

### hw/rtl/fgcc_point.sv
// Point pipeline: rotate, translate, bound and index one lattice point per cycle.
module fgcc_point (
    input  logic                        clk,
    input  logic                        rst_n,
    input  fgcc_pkg::fgcc_ctx_t         ctx,
    input  fgcc_pkg::fgcc_pt_t          pt,
    output logic                        busy,
    output logic                        rd_en,
    output logic [fgcc_pkg::MAP_AW-1:0] rd_addr
);
    import fgcc_pkg::*;

    // stage A: sy products
    logic a_v_reg;
    logic signed [FPROD_W-1:0] a_fxc_reg, a_fxs_reg, a_fys_reg, a_fyc_reg;
    logic signed [PROD_W-1:0]  pys, pyc;
    // stage B: map coordinates
    logic b_v_reg;
    logic signed [MAPC_W-1:0] b_mx_reg, b_my_reg, mx_c, my_c;
    // stage C: bounds
    logic c_v_reg;
    logic [LIM_W-1:0] c_mx_reg, c_my_reg;
    logic in_c;
    // stage D: reciprocal estimate
    logic d_v_reg;
    logic [LIM_W-1:0]  d_mx_reg, d_my_reg;
    logic [QUOT_W-1:0] d_qx_reg, d_qy_reg;
    logic [LIM_W+RECIP_W-1:0] prx, pry;
    // stage E: corrected cell column and row
    logic e_v_reg;
    logic [DIM_W-1:0] e_cx_reg, e_cy_reg, cx_c, cy_c;
    logic [LIM_W:0]   qcx, qcy, rx, ry;
    logic [IDX_W-1:0] idx;

    assign pys = pt.sy * ctx.s;
    assign pyc = pt.sy * ctx.c;

    assign mx_c = {{(MAPC_W-POSE_W){ctx.px[POSE_W-1]}}, ctx.px}
                + {{(MAPC_W-FPROD_W){a_fxc_reg[FPROD_W-1]}}, a_fxc_reg}
                + {{(MAPC_W-FPROD_W){a_fys_reg[FPROD_W-1]}}, a_fys_reg};
    assign my_c = {{(MAPC_W-POSE_W){ctx.py[POSE_W-1]}}, ctx.py}
                - {{(MAPC_W-FPROD_W){a_fxs_reg[FPROD_W-1]}}, a_fxs_reg}
                + {{(MAPC_W-FPROD_W){a_fyc_reg[FPROD_W-1]}}, a_fyc_reg};

    // drop points off the active map before any division
    assign in_c = !b_mx_reg[MAPC_W-1] && !b_my_reg[MAPC_W-1]
               && (b_mx_reg < $signed({{(MAPC_W-LIM_W){1'b0}}, ctx.lx}))
               && (b_my_reg < $signed({{(MAPC_W-LIM_W){1'b0}}, ctx.ly}));

    assign prx = c_mx_reg * ctx.recip;
    assign pry = c_my_reg * ctx.recip;

    // estimate is low by at most one: fix with one compare
    assign qcx = d_qx_reg * ctx.cs;
    assign qcy = d_qy_reg * ctx.cs;
    assign rx  = {1'b0, d_mx_reg} - qcx;
    assign ry  = {1'b0, d_my_reg} - qcy;
    assign cx_c = (rx >= {{(LIM_W+1-EXT_W){1'b0}}, ctx.cs}) ? DIM_W'(d_qx_reg + 1'b1)
                                                            : DIM_W'(d_qx_reg);
    assign cy_c = (ry >= {{(LIM_W+1-EXT_W){1'b0}}, ctx.cs}) ? DIM_W'(d_qy_reg + 1'b1)
                                                            : DIM_W'(d_qy_reg);

    assign idx     = {{(IDX_W-DIM_W){1'b0}}, e_cx_reg} + e_cy_reg * ctx.width;
    assign rd_en   = e_v_reg && (idx[IDX_W-1:MAP_AW] == '0);
    assign rd_addr = idx[MAP_AW-1:0];
    assign busy    = a_v_reg || b_v_reg || c_v_reg || d_v_reg || e_v_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_v_reg <= 1'b0;
            b_v_reg <= 1'b0;
            c_v_reg <= 1'b0;
            d_v_reg <= 1'b0;
            e_v_reg <= 1'b0;
        end
        else
        begin
            a_v_reg <= pt.valid;
            b_v_reg <= a_v_reg;
            c_v_reg <= b_v_reg && in_c;
            d_v_reg <= c_v_reg;
            e_v_reg <= d_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        a_fxc_reg <= pt.fxc;
        a_fxs_reg <= pt.fxs;
        a_fys_reg <= pys[PROD_W-1:TRIG_FRAC_BITS];
        a_fyc_reg <= pyc[PROD_W-1:TRIG_FRAC_BITS];
        b_mx_reg  <= mx_c;
        b_my_reg  <= my_c;
        c_mx_reg  <= b_mx_reg[LIM_W-1:0];
        c_my_reg  <= b_my_reg[LIM_W-1:0];
        d_mx_reg  <= c_mx_reg;
        d_my_reg  <= c_my_reg;
        d_qx_reg  <= prx[RECIP_SH+QUOT_W-1:RECIP_SH];
        d_qy_reg  <= pry[RECIP_SH+QUOT_W-1:RECIP_SH];
        e_cx_reg  <= cx_c;
        e_cy_reg  <= cy_c;
    end

endmodule

### hw/rtl/footprint_grid_collision_check.sv
// Top level of the footprint collision checker: sequencer, registers and occupancy map.
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+---------------------------------------------
//  in      | input     | in_valid / in_ready  | command, cell_index, cell_free, pose, heading
//  out     | output    | out_valid / out_ready| in_collision
//  cfg     | input     | cfg_we               | cfg_addr, cfg_data
//
// A map write is taken in ST_IDLE and leaves the sequencer idle. A query first runs the
// bit-serial cell-size reciprocal, then walks the lattice (ST_ROW per row, ST_COL per point,
// at most one map read per point), drains the pipeline and loads the result; the reset
// footprint is 54 rows of 33 points.
// The single map read port sets the walk rate. One item is in work at a time.
// Reset clears control state only; the map content is undefined until written.
// A finished result waits in the output register while the next item is taken.
module footprint_grid_collision_check (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic                               command,
    input  logic [15:0]                        cell_index,
    input  logic                               cell_free,
    input  logic signed [fgcc_pkg::POSE_W-1:0] pose_x,
    input  logic signed [fgcc_pkg::POSE_W-1:0] pose_y,
    input  logic signed [fgcc_pkg::TRIG_W-1:0] heading_cos,
    input  logic signed [fgcc_pkg::TRIG_W-1:0] heading_sin,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic                               in_collision,
    input  logic                               cfg_we,
    input  logic [2:0]                         cfg_addr,
    input  logic [fgcc_pkg::EXT_W-1:0]         cfg_data
);
    import fgcc_pkg::*;

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_RECIP = 6'b000010,
        ST_ROW   = 6'b000100,
        ST_COL   = 6'b001000,
        ST_DRAIN = 6'b010000,
        ST_DONE  = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    // configuration registers
    logic [DIM_W-1:0] width_reg, height_reg;
    logic [EXT_W-1:0] cell_reg, rear_reg, front_reg, side_reg;

    // query context and walk position
    fgcc_ctx_t ctx_reg, ctx_next;
    logic signed [LAT_W-1:0]   sx_reg, sx_next, sy_reg, sy_next;
    logic signed [FPROD_W-1:0] fxc_reg, fxc_next, fxs_reg, fxs_next;
    logic signed [PROD_W-1:0]  rowc, rows;
    logic signed [LAT_W-1:0]   sy_step, sx_step, cs_s, front_s, side_s;
    logic [EXT_W-1:0]          cs_eff;
    logic hit_reg, hit_next;
    logic out_valid_reg, out_valid_next, out_coll_reg, out_coll_next;

    logic             div_start, div_done;
    logic [RECIP_W-1:0] recip;
    fgcc_pt_t         pt;
    logic             pt_issue, pt_busy;
    logic             rd_en, rdv_reg, rdata;
    logic [MAP_AW-1:0] rd_addr;
    logic             ram_we, in_xfer;
    logic             in_walk;

    assign in_ready = (state_reg == ST_IDLE);
    assign in_xfer  = in_valid && in_ready;
    assign ram_we   = in_xfer && (command == CMD_WRITE);
    assign in_walk  = (state_reg == ST_COL) || (state_reg == ST_ROW) || (state_reg == ST_DRAIN);

    // lattice step never below the minimum cell
    assign cs_eff  = (cell_reg < EXT_W'(MIN_CELL)) ? EXT_W'(MIN_CELL) : cell_reg;
    assign cs_s    = $signed({2'b00, ctx_reg.cs});
    assign front_s = $signed({2'b00, front_reg});
    assign side_s  = $signed({2'b00, side_reg});
    assign sy_step = sy_reg + cs_s;
    assign sx_step = sx_reg + cs_s;
    assign rowc    = sx_reg * ctx_reg.c;
    assign rows    = sx_reg * ctx_reg.s;

    assign pt_issue  = (state_reg == ST_COL);
    assign pt.valid  = pt_issue;
    assign pt.sy     = sy_reg;
    assign pt.fxc    = fxc_reg;
    assign pt.fxs    = fxs_reg;
    assign div_start = in_xfer && (command == CMD_QUERY);

    always_comb
    begin
        state_next     = state_reg;
        ctx_next       = ctx_reg;
        sx_next        = sx_reg;
        sy_next        = sy_reg;
        fxc_next       = fxc_reg;
        fxs_next       = fxs_reg;
        hit_next       = hit_reg;
        out_valid_next = out_valid_reg;
        out_coll_next  = out_coll_reg;

        // drop the result once the far side takes the transfer
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        // accumulate hits from the map read port
        if (rdv_reg && !rdata)
        begin
            hit_next = 1'b1;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (div_start)
                begin
                    ctx_next.px    = pose_x;
                    ctx_next.py    = pose_y;
                    ctx_next.c     = heading_cos;
                    ctx_next.s     = heading_sin;
                    ctx_next.cs    = cs_eff;
                    ctx_next.lx    = width_reg * cs_eff;
                    ctx_next.ly    = height_reg * cs_eff;
                    ctx_next.width = width_reg;
                    sx_next        = -$signed({2'b00, rear_reg});
                    hit_next       = 1'b0;
                    state_next     = ST_RECIP;
                end
            end
            ST_RECIP:
            begin
                if (div_done)
                begin
                    ctx_next.recip = recip;
                    // empty lattice in either direction: nothing to check
                    if ((sx_reg >= front_s) || (side_reg == '0))
                    begin
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        state_next = ST_ROW;
                    end
                end
            end
            ST_ROW:
            begin
                fxc_next   = rowc[PROD_W-1:TRIG_FRAC_BITS];
                fxs_next   = rows[PROD_W-1:TRIG_FRAC_BITS];
                sy_next    = -side_s;
                state_next = ST_COL;
            end
            ST_COL:
            begin
                // advance across; at the row end advance along the car
                sy_next = sy_step;
                if (sy_step >= side_s)
                begin
                    sx_next = sx_step;
                    if (sx_step >= front_s)
                    begin
                        state_next = ST_DRAIN;
                    end
                    else
                    begin
                        state_next = ST_ROW;
                    end
                end
            end
            ST_DRAIN:
            begin
                if (!pt_busy && !rdv_reg)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                // hold until the output register is free
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    out_coll_next  = hit_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            rdv_reg       <= 1'b0;
            width_reg     <= '0;
            height_reg    <= '0;
            cell_reg      <= CELL_RST;
            rear_reg      <= REAR_RST;
            front_reg     <= FRONT_RST;
            side_reg      <= SIDE_RST;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            rdv_reg       <= rd_en;
            if (cfg_we)
            begin
                unique case (cfg_addr)
                    REG_MAP_WIDTH:  width_reg  <= cfg_data[DIM_W-1:0];
                    REG_MAP_HEIGHT: height_reg <= cfg_data[DIM_W-1:0];
                    REG_CELL_SIZE:  cell_reg   <= cfg_data;
                    REG_REAR:       rear_reg   <= cfg_data;
                    REG_FRONT:      front_reg  <= cfg_data;
                    REG_SIDE:       side_reg   <= cfg_data;
                    default:        ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        ctx_reg      <= ctx_next;
        sx_reg       <= sx_next;
        sy_reg       <= sy_next;
        fxc_reg      <= fxc_next;
        fxs_reg      <= fxs_next;
        hit_reg      <= hit_next;
        out_coll_reg <= out_coll_next;
    end

    fgcc_recip u_recip (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (div_start),
        .divisor (cs_eff),
        .done    (div_done),
        .quot    (recip)
    );

    fgcc_point u_point (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctx     (ctx_reg),
        .pt      (pt),
        .busy    (pt_busy),
        .rd_en   (rd_en),
        .rd_addr (rd_addr)
    );

    fgcc_ram #(
        .WIDTH (1),
        .DEPTH (MAP_CELLS)
    ) u_map (
        .clk   (clk),
        .we    (ram_we),
        .waddr (cell_index[MAP_AW-1:0]),
        .wdata (cell_free),
        .re    (rd_en),
        .raddr (rd_addr),
        .rdata (rdata)
    );

    assign out_valid    = out_valid_reg;
    assign in_collision = out_coll_reg;

    `include "footprint_grid_collision_check_assert.svh"

    `FGCC_ASSERT_IMP(a_write_only_idle, ram_we, state_reg == ST_IDLE)
    `FGCC_ASSERT_IMP(a_done_drained, state_reg == ST_DONE, !pt_busy && !rdv_reg)
    `FGCC_ASSERT_NXT(a_query_starts_recip, div_start, state_reg == ST_RECIP)
    `FGCC_ASSERT_IMP(a_read_in_walk, rd_en, in_walk)

endmodule

### dv/fgcc_checker.sv
// Scoreboard for the footprint collision checker: mirrors map and registers, predicts, compares.
module fgcc_checker (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    input  logic                               in_ready,
    input  logic                               command,
    input  logic [15:0]                        cell_index,
    input  logic                               cell_free,
    input  logic signed [fgcc_pkg::POSE_W-1:0] pose_x,
    input  logic signed [fgcc_pkg::POSE_W-1:0] pose_y,
    input  logic signed [fgcc_pkg::TRIG_W-1:0] heading_cos,
    input  logic signed [fgcc_pkg::TRIG_W-1:0] heading_sin,
    input  logic                               out_valid,
    input  logic                               out_ready,
    input  logic                               in_collision,
    input  logic                               cfg_we,
    input  logic [2:0]                         cfg_addr,
    input  logic [fgcc_pkg::EXT_W-1:0]         cfg_data,
    output int                                 fail_count,
    output int                                 pending
);
    import fgcc_pkg::*;

    bit               free_map [0:MAP_CELLS-1];
    logic [DIM_W-1:0] width_r;
    logic [DIM_W-1:0] height_r;
    logic [EXT_W-1:0] cell_r;
    logic [EXT_W-1:0] rear_r;
    logic [EXT_W-1:0] front_r;
    logic [EXT_W-1:0] side_r;
    // expected results in order of query transfer
    bit               exp_fifo [0:15];
    logic [3:0]       head_r;
    logic [3:0]       tail_r;

    task automatic report_mismatch(string what, bit got, bit want);
        $display("[%0t] MISMATCH %s: got %0d, expected %0d", $realtime, what, got, want);
        fail_count++;
    endtask

    // Walk the footprint lattice; true on the first point over an occupied cell.
    function automatic bit footprint_hits(longint px, longint py, longint c, longint s);
        longint step, sx, sy, mx, my, cx, cy, idx;
        step = (cell_r < MIN_CELL) ? MIN_CELL : longint'(cell_r);
        for (sx = -longint'(rear_r); sx < longint'(front_r); sx += step)
        begin
            for (sy = -longint'(side_r); sy < longint'(side_r); sy += step)
            begin
                mx = px + ((sx * c) >>> TRIG_FRAC_BITS) + ((sy * s) >>> TRIG_FRAC_BITS);
                my = py - ((sx * s) >>> TRIG_FRAC_BITS) + ((sy * c) >>> TRIG_FRAC_BITS);
                if (mx >= 0 && my >= 0)
                begin
                    cx = mx / step;
                    cy = my / step;
                    if (cx < longint'(width_r) && cy < longint'(height_r))
                    begin
                        idx = cx + cy * longint'(width_r);
                        if (idx < MAP_CELLS && !free_map[idx])
                            return 1'b1;
                    end
                end
            end
        end
        return 1'b0;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_r    = '0;
            height_r   = '0;
            cell_r     = CELL_RST;
            rear_r     = REAR_RST;
            front_r    = FRONT_RST;
            side_r     = SIDE_RST;
            head_r     = '0;
            tail_r     = '0;
            fail_count = 0;
            pending    = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_addr)
                    REG_MAP_WIDTH:  width_r  = cfg_data[DIM_W-1:0];
                    REG_MAP_HEIGHT: height_r = cfg_data[DIM_W-1:0];
                    REG_CELL_SIZE:  cell_r   = cfg_data;
                    REG_REAR:       rear_r   = cfg_data;
                    REG_FRONT:      front_r  = cfg_data;
                    REG_SIDE:       side_r   = cfg_data;
                    default: ;
                endcase
            end
            if (out_valid && out_ready)
            begin
                if (pending == 0)
                    report_mismatch("unexpected result", in_collision, 1'b0);
                else
                begin
                    if (in_collision !== exp_fifo[head_r])
                        report_mismatch("in_collision", in_collision, exp_fifo[head_r]);
                    head_r  = 4'(head_r + 4'd1);
                    pending = pending - 1;
                end
            end
            if (in_valid && in_ready)
            begin
                if (command == CMD_WRITE)
                    free_map[cell_index] = cell_free;
                else
                begin
                    exp_fifo[tail_r] = footprint_hits(pose_x, pose_y,
                                                      heading_cos, heading_sin);
                    tail_r  = 4'(tail_r + 4'd1);
                    pending = pending + 1;
                end
            end
        end
    end

endmodule

### dv/tb_top.sv
// Stimulus, clock, reset and verdict for the footprint collision checker.
module tb_top;
    import fgcc_pkg::*;

    localparam int STALL_LIMIT = 20000;

    logic                     clk;
    logic                     rst_n;
    logic                     in_valid;
    logic                     in_ready;
    logic                     command;
    logic [15:0]              cell_index;
    logic                     cell_free;
    logic signed [POSE_W-1:0] pose_x;
    logic signed [POSE_W-1:0] pose_y;
    logic signed [TRIG_W-1:0] heading_cos;
    logic signed [TRIG_W-1:0] heading_sin;
    logic                     out_valid;
    logic                     out_ready;
    logic                     in_collision;
    logic                     cfg_we;
    logic [2:0]               cfg_addr;
    logic [EXT_W-1:0]         cfg_data;
    int                       fail_count;
    int                       pending;

    // Once set, neither side idles any more.
    bit calm;
    int map_w, map_h, map_cs, occ_pct;

    footprint_grid_collision_check DUT (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .command(command), .cell_index(cell_index), .cell_free(cell_free),
        .pose_x(pose_x), .pose_y(pose_y),
        .heading_cos(heading_cos), .heading_sin(heading_sin),
        .out_valid(out_valid), .out_ready(out_ready), .in_collision(in_collision),
        .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_data(cfg_data)
    );

    fgcc_checker u_checker (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .command(command), .cell_index(cell_index), .cell_free(cell_free),
        .pose_x(pose_x), .pose_y(pose_y),
        .heading_cos(heading_cos), .heading_sin(heading_sin),
        .out_valid(out_valid), .out_ready(out_ready), .in_collision(in_collision),
        .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_data(cfg_data),
        .fail_count(fail_count), .pending(pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Result side: mostly ready, with random stall bursts until calm.
    initial
    begin
        int hold;
        hold = 0;
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold > 0)
            begin
                hold--;
                out_ready <= 1'b0;
            end
            else if (!calm && $urandom_range(0, 5) == 0)
            begin
                hold = $urandom_range(1, 10) - 1;
                out_ready <= 1'b0;
            end
            else
                out_ready <= 1'b1;
        end
    end

    // Watchdog: count cycles with no transfer on either channel.
    initial
    begin
        int stall;
        stall = 0;
        while (stall < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready))
                stall = 0;
            else
                stall++;
        end
        $display("Test completed with failures");
        $finish;
    end

    // Present one item and hold it until the transfer; may idle first.
    // Entered and left just after a falling edge.
    task automatic send_item(logic cmd, logic [15:0] idx, logic free,
                             logic signed [POSE_W-1:0] px, logic signed [POSE_W-1:0] py,
                             logic signed [TRIG_W-1:0] c, logic signed [TRIG_W-1:0] s);
        if (!calm && $urandom_range(0, 5) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(negedge clk);
        end
        command     <= cmd;
        cell_index  <= idx;
        cell_free   <= free;
        pose_x      <= px;
        pose_y      <= py;
        heading_cos <= c;
        heading_sin <= s;
        in_valid    <= 1'b1;
        forever
        begin
            @(posedge clk);
            if (in_ready)
                break;
        end
        @(negedge clk);
    endtask

    task automatic send_write(logic [15:0] idx, logic free);
        send_item(CMD_WRITE, idx, free, POSE_W'($urandom), POSE_W'($urandom),
                  TRIG_W'($urandom), TRIG_W'($urandom));
    endtask

    task automatic send_query(int px, int py, int c, int s);
        send_item(CMD_QUERY, 16'($urandom), 1'($urandom), px[POSE_W-1:0], py[POSE_W-1:0],
                  c[TRIG_W-1:0], s[TRIG_W-1:0]);
    endtask

    // Drop valid, wait for every result, then let the last write settle.
    task automatic drain;
        in_valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (8) @(negedge clk);
    endtask

    // Program all registers while idle, then fill the active map region.
    task automatic set_up(int w, int h, int cs, int rear, int front, int side, int occ);
        int vals [6];
        vals = '{w, h, cs, rear, front, side};
        drain();
        for (int i = 0; i < 6; i++)
        begin
            cfg_we   <= 1'b1;
            cfg_addr <= 3'(i);
            cfg_data <= EXT_W'(vals[i]);
            @(negedge clk);
        end
        cfg_we <= 1'b0;
        map_w   = w;
        map_h   = h;
        map_cs  = (cs < MIN_CELL) ? MIN_CELL : cs;
        occ_pct = occ;
        for (int i = 0; i < w * h; i++)
            send_write(16'(i), $urandom_range(0, 99) >= occ);
    endtask

    task automatic random_heading(output int c, output int s);
        case ($urandom_range(0, 5))
            0:
            begin
                c = 16384;  s = 0;
            end
            1:
            begin
                c = 0;      s = -16384;
            end
            2:
            begin
                c = 11585;  s = -11585;
            end
            3:
            begin
                c = -11585; s = 11585;
            end
            default:
            begin
                c = $urandom_range(0, 32768) - 16384;
                s = $urandom_range(0, 32768) - 16384;
            end
        endcase
    endtask

    // Random mix: mostly queries around the active map, some writes, a little noise.
    task automatic random_items(int n);
        int span_x, span_y, px, py, c, s;
        span_x = map_w * map_cs;
        span_y = map_h * map_cs;
        for (int k = 0; k < n; k++)
        begin
            if ($urandom_range(0, 2) == 0)
            begin
                if (map_w * map_h > 0 && $urandom_range(0, 7) != 0)
                    send_write(16'($urandom_range(0, map_w * map_h - 1)),
                               $urandom_range(0, 99) >= occ_pct);
                else if (map_w * map_h == 0)
                    send_write(16'($urandom), 1'($urandom));
                else
                    // beyond the active region, so no later read can see it
                    send_write(16'($urandom_range(map_w * map_h, 65535)), 1'($urandom));
            end
            else
            begin
                random_heading(c, s);
                if ($urandom_range(0, 9) == 0)
                begin
                    px = $urandom_range(0, 16777215) - 8388608;
                    py = $urandom_range(0, 16777215) - 8388608;
                end
                else
                begin
                    px = $urandom_range(0, span_x + 4 * map_cs) - 2 * map_cs;
                    py = $urandom_range(0, span_y + 4 * map_cs) - 2 * map_cs;
                end
                send_query(px, py, c, s);
            end
        end
    endtask

    initial
    begin
        calm        = 1'b0;
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        command     = CMD_WRITE;
        cell_index  = '0;
        cell_free   = 1'b0;
        pose_x      = '0;
        pose_y      = '0;
        heading_cos = '0;
        heading_sin = '0;
        cfg_we      = 1'b0;
        cfg_addr    = '0;
        cfg_data    = '0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Empty map straight after reset: reset extents, no map read.
        send_query(1000, 1000, 16384, 0);

        // Reset-sized footprint on a 6 x 6 map, plus directed corners.
        set_up(6, 6, 51, 666, 2079, 819, 2);
        send_query(0, 0, 16384, 0);
        send_query(8388607, 8388607, -16384, 0);
        send_query(-8388608, -8388608, 0, -16384);
        send_query(408, 408, 0, 16384);
        send_query(408, 300, 11585, -11585);
        send_query(800, 816, -16384, 16384);
        send_write(16'hFFFF, 1'b0);
        send_write(16'd0, 1'b0);
        send_query(0, 0, 16384, 0);
        send_write(16'd0, 1'b1);
        random_items(15);

        // Wide map, one row, smallest cell.
        set_up(32, 1, 16, 64, 64, 64, 5);
        random_items(12);

        // Tall map, one column; cell size below the floor.
        set_up(1, 24, 0, 48, 48, 48, 5);
        random_items(12);

        // Cells and extents of 4096.
        set_up(4, 4, 4096, 4096, 4096, 4096, 10);
        random_items(8);

        // Empty footprint, then empty maps.
        set_up(6, 5, 100, 0, 0, 300, 20);
        random_items(6);
        set_up(0, 5, 40, 100, 100, 100, 20);
        random_items(4);
        set_up(20, 0, 40, 100, 100, 0, 20);
        random_items(4);

        set_up(8, 6, 37, 200, 500, 150, 3);
        random_items(15);

        // Closing stretch with no idling on either side.
        calm = 1'b1;
        set_up(5, 6, 60, 300, 700, 250, 4);
        random_items(15);

        drain();
        repeat (20) @(posedge clk);
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

### sim.f
+incdir+hw/rtl
hw/rtl/fgcc_pkg.sv
hw/rtl/fgcc_ram.sv
hw/rtl/fgcc_recip.sv
hw/rtl/fgcc_point.sv
hw/rtl/footprint_grid_collision_check.sv
dv/fgcc_checker.sv
dv/tb_top.sv
